>>> hw/rtl/sacl_pkg.sv
package sacl_pkg;

  // Geometry of the cache model
  localparam int ADDR_BITS      = 48;
  localparam int MAX_SET_BITS   = 6;
  localparam int MAX_WAYS       = 8;
  localparam int BLOCK_BITS_MAX = 16;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int TOTAL_W  = 32;

  // Configuration field widths
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int OP_W         = 2;

  // Access kind that counts twice
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // One way of a set: valid, tag and recency rank (0 is most recent)
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [WAY_W-1:0]     rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the access and read its set
    logic update;  // write the set back, bump totals, load the result
  } cmd_t;

endpackage

>>> hw/rtl/sacl_ctrl.sv
module sacl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          access_valid,
  output logic          access_ready,
  output logic          result_valid,
  input  logic          result_ready,
  output sacl_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   slot_free;

  // Output slot can take a new word when empty or being drained
  assign slot_free    = !result_valid || result_ready;
  assign access_ready = (state == S_IDLE);
  assign cmd.load     = (state == S_IDLE) && access_valid;
  assign cmd.update   = (state == S_LOOKUP) && slot_free;

  // Advance between set read and write back
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (access_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.update) result_valid_next = 1'b1;
    else if (result_ready) result_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

>>> hw/rtl/sacl_dp.sv
module sacl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sacl_pkg::cmd_t                      cmd,
  input  logic [sacl_pkg::SET_BITS_W-1:0]     set_bits,
  input  logic [sacl_pkg::BLOCK_BITS_W-1:0]   block_bits,
  input  logic [sacl_pkg::WAYS_W-1:0]         ways_in_use,
  input  logic [sacl_pkg::OP_W-1:0]           op,
  input  logic [sacl_pkg::ADDR_BITS-1:0]      address,
  output logic                                was_hit,
  output logic                                was_miss,
  output logic                                was_evict,
  output logic [sacl_pkg::TOTAL_W-1:0]        hit_total,
  output logic [sacl_pkg::TOTAL_W-1:0]        miss_total,
  output logic [sacl_pkg::TOTAL_W-1:0]        evict_total
);

  localparam int AW = sacl_pkg::ADDR_BITS;
  localparam int SW = sacl_pkg::SET_W;
  localparam int WW = sacl_pkg::WAY_W;
  localparam int CW = sacl_pkg::CNT_W;
  localparam int TW = sacl_pkg::TOTAL_W;
  localparam int NW = sacl_pkg::MAX_WAYS;
  localparam logic [WW-1:0] RANK_MAX = WW'(sacl_pkg::MAX_WAYS - 1);

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW+1)'(b);
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // Set memory and per-row valid flags (an unwritten row reads as zero)
  sacl_pkg::row_t mem [sacl_pkg::NUM_SETS];
  logic [sacl_pkg::NUM_SETS-1:0] row_written;

  // Access latched at accept
  logic [sacl_pkg::OP_W-1:0]         op_q;
  logic [SW-1:0]                     set_q;
  logic [AW-1:0]                     tag_q;
  logic [CW-1:0]                     n_q;
  sacl_pkg::row_t                    rd_data;
  logic                              rd_ok;

  // Address split
  logic [sacl_pkg::SET_BITS_W-1:0]   s_eff;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] b_eff;
  logic [CW-1:0]                     n_eff;
  logic [AW-1:0]                     addr_sh;
  logic [SW:0]                       set_lim;
  logic [SW-1:0]                     set_idx;
  logic [5:0]                        tag_shift;
  logic [AW-1:0]                     tag_new;

  // Lookup
  sacl_pkg::row_t                    row;
  sacl_pkg::row_t                    row_new;
  logic                              hit;
  logic                              found_free;
  logic                              evict;
  logic [WW-1:0]                     hit_way;
  logic [WW-1:0]                     free_way;
  logic [WW-1:0]                     lru_way;
  logic [WW-1:0]                     best_rank;
  logic [WW-1:0]                     way_sel;
  logic [WW-1:0]                     old_rank;
  logic [NW-1:0]                     in_use;
  logic [1:0]                        hit_inc;

  // Clamp configuration and split the incoming address
  always_comb begin
    s_eff = (32'(set_bits) > 32'(sacl_pkg::MAX_SET_BITS))
            ? sacl_pkg::SET_BITS_W'(sacl_pkg::MAX_SET_BITS) : set_bits;
    b_eff = (32'(block_bits) > 32'(sacl_pkg::BLOCK_BITS_MAX))
            ? sacl_pkg::BLOCK_BITS_W'(sacl_pkg::BLOCK_BITS_MAX) : block_bits;
    if (ways_in_use == '0) n_eff = CW'(1);
    else if (32'(ways_in_use) > 32'(NW)) n_eff = CW'(NW);
    else n_eff = CW'(ways_in_use);
    addr_sh   = address >> b_eff;
    set_lim   = (SW+1)'(1) << s_eff;
    set_idx   = addr_sh[SW-1:0] & SW'(set_lim - (SW+1)'(1));
    tag_shift = 6'(s_eff) + 6'(b_eff);
    tag_new   = address >> tag_shift;
  end

  // Latch the access and read its set
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      set_q   <= set_idx;
      tag_q   <= tag_new;
      n_q     <= n_eff;
      rd_data <= mem[set_idx];
    end
    if (cmd.update) mem[set_q] <= row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      rd_ok       <= 1'b0;
    end else begin
      if (cmd.load) rd_ok <= row_written[set_idx];
      if (cmd.update) row_written[set_q] <= 1'b1;
    end
  end

  // Search the set: first matching way, first free way, least recent way
  always_comb begin
    row        = rd_ok ? rd_data : '0;
    hit        = 1'b0;
    found_free = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    for (int j = 0; j < NW; j++) begin
      in_use[j] = (CW'(j) < n_q);
      if (in_use[j] && row[j].valid && row[j].tag == tag_q && !hit) begin
        hit     = 1'b1;
        hit_way = WW'(j);
      end
      if (in_use[j] && !row[j].valid && !found_free) begin
        found_free = 1'b1;
        free_way   = WW'(j);
      end
    end
    lru_way   = '0;
    best_rank = row[0].rank;
    for (int j = 1; j < NW; j++) begin
      if (in_use[j] && row[j].rank > best_rank) begin
        best_rank = row[j].rank;
        lru_way   = WW'(j);
      end
    end
    evict   = !hit && !found_free;
    way_sel = hit ? hit_way : (found_free ? free_way : lru_way);
    old_rank = row[way_sel].rank;
  end

  // Build the write-back row: fill on miss, promote the touched way
  always_comb begin
    row_new = row;
    for (int j = 0; j < NW; j++) begin
      if (WW'(j) == way_sel) begin
        row_new[j].rank = '0;
        if (!hit) begin
          row_new[j].valid = 1'b1;
          row_new[j].tag   = tag_q;
        end
      end else if (in_use[j] && row[j].rank <= old_rank && row[j].rank < RANK_MAX) begin
        row_new[j].rank = row[j].rank + WW'(1);
      end
    end
  end

  // A modify adds one hit beyond the load's outcome
  always_comb begin
    if (hit) hit_inc = (op_q == sacl_pkg::OP_MODIFY) ? 2'd2 : 2'd1;
    else     hit_inc = (op_q == sacl_pkg::OP_MODIFY) ? 2'd1 : 2'd0;
  end

  // Running totals double as the result word's total fields
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
    end else if (cmd.update) begin
      hit_total   <= sat_add(hit_total, hit_inc);
      miss_total  <= sat_add(miss_total, {1'b0, !hit});
      evict_total <= sat_add(evict_total, {1'b0, evict});
    end
  end

  // Result flags
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      was_hit   <= hit;
      was_miss  <= !hit;
      was_evict <= evict;
    end
  end

endmodule

>>> hw/rtl/set_assoc_cache_lru_sim_unit.sv
// Set-associative cache simulator with least-recently-used replacement.
// Access channel (access_valid/access_ready): one word per access, op
// (0 load, 1 store, 2 modify, 3 treated as load) and a 48-bit byte address.
// Result channel (result_valid/result_ready): hit, miss and evict flags and
// the saturating running hit, miss and eviction totals after the access.
// Each access reads its set from the set memory, then searches the ways and
// writes the set back. The result is valid from the cycle after the write
// back, and a new access can be taken in that same cycle; no access is taken
// while the previous one is still in its lookup.
// The next access is accepted while a result is still waiting; if the
// receiver stalls, that access holds in its lookup until the result is taken.
// Reset clears the totals, marks every set empty (per-set flags, no sweep)
// and loads set_bits 4, block_bits 4, ways_in_use 8. Registers sit on an
// APB-style port at 0x0, 0x4, 0x8; write them only while the block is idle.
module set_assoc_cache_lru_sim_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                access_valid,
  output logic                                access_ready,
  input  logic [sacl_pkg::OP_W-1:0]           op,
  input  logic [sacl_pkg::ADDR_BITS-1:0]      address,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                was_hit,
  output logic                                was_miss,
  output logic                                was_evict,
  output logic [sacl_pkg::TOTAL_W-1:0]        hit_total,
  output logic [sacl_pkg::TOTAL_W-1:0]        miss_total,
  output logic [sacl_pkg::TOTAL_W-1:0]        evict_total
);

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits;
  logic [sacl_pkg::WAYS_W-1:0]       ways_in_use;
  logic                              cfg_write;
  sacl_pkg::cmd_t                    cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::SET_BITS_W'(4);
      block_bits  <= sacl_pkg::BLOCK_BITS_W'(4);
      ways_in_use <= sacl_pkg::WAYS_W'(8);
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        sacl_pkg::REG_SET_BITS:   set_bits    <= pwdata[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::REG_BLOCK_BITS: block_bits  <= pwdata[sacl_pkg::BLOCK_BITS_W-1:0];
        sacl_pkg::REG_WAYS:       ways_in_use <= pwdata[sacl_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      sacl_pkg::REG_SET_BITS:   prdata = 32'(set_bits);
      sacl_pkg::REG_BLOCK_BITS: prdata = 32'(block_bits);
      sacl_pkg::REG_WAYS:       prdata = 32'(ways_in_use);
      default:                  prdata = '0;
    endcase
  end

  sacl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  sacl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .set_bits     (set_bits),
    .block_bits   (block_bits),
    .ways_in_use  (ways_in_use),
    .op           (op),
    .address      (address),
    .was_hit      (was_hit),
    .was_miss     (was_miss),
    .was_evict    (was_evict),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .evict_total  (evict_total)
  );

endmodule
